// ===== hw/rtl/pcmf_pkg.sv =====
// Shared constants, types and the controller state encoding for the
// per-channel median filter. No dependencies.
`timescale 1ns / 1ps

package pcmf_pkg;

	localparam int CHANNELS = 4;
	localparam int WINDOW   = 10;

	localparam int SAMPLE_W = 12;
	localparam int CHAN_W   = 2;

	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);

	// Ranks (from zero) of the two middle values of the sorted window.
	localparam int MID_LO = (WINDOW - 1) / 2;
	localparam int MID_HI = WINDOW / 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} pcmf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic write;
		logic clear_sort;
		logic rd_issue;
		logic out_load;
	} pcmf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_last;
		logic out_free;
	} pcmf_sts_t;

endpackage

// ===== hw/rtl/per_channel_median_filter.sv =====
// Per-channel sliding-window median filter, top level.
// An accepted request passes the write, read, drain and finish states, the
// single read port of the window memory being read once per stored entry; a
// new request is accepted only after the result enters the output register.
// Reset (arst_n, asynchronous) empties every window to zeros through valid
// bits and clears the slot pointers; no clearing pass is needed.
`timescale 1ns / 1ps

module per_channel_median_filter
	import pcmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAN_W-1:0]   channel_out,
	output logic [SAMPLE_W-1:0] filtered
);

	// The controller sequences each request: write the new sample over the
	// channel's oldest entry, stream the channel's window out of memory one
	// entry per cycle into the insertion sorter, then average the two middle
	// ranks into the output register. The output register lets a new request
	// be accepted while the previous result still waits to be taken.
	pcmf_cmd_t cmd;
	pcmf_sts_t sts;

	pcmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds all storage; a channel index beyond the configured
	// count leaves the state alone and reports a filtered value of zero.
	pcmf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.channel     (channel),
		.sample      (sample),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel_out (channel_out),
		.filtered    (filtered)
	);

endmodule

// ===== hw/rtl/pcmf_ctrl.sv =====
// Controller state machine of the per-channel median filter.
// Depends on pcmf_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module pcmf_ctrl
	import pcmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pcmf_sts_t   sts,
	output pcmf_cmd_t   cmd
);

	pcmf_state_t state_q;
	pcmf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write      = 1'b1;
				cmd.clear_sort = 1'b1;
				state_d        = ST_READ;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last window entry is inserted into the sorter here.
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/pcmf_dp.sv =====
// Datapath of the per-channel median filter: window memory with per-entry
// valid bits, oldest-slot pointers, insertion sorter and output register.
// Depends on pcmf_pkg.
`timescale 1ns / 1ps

module pcmf_dp
	import pcmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [SAMPLE_W-1:0] sample,
	input  pcmf_cmd_t           cmd,
	output pcmf_sts_t           sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAN_W-1:0]   channel_out,
	output logic [SAMPLE_W-1:0] filtered
);

	logic [CHAN_W-1:0]   chan_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                chan_ok_q;

	logic [SLOT_W-1:0]   slot_q [CHANNELS];
	logic [SLOT_W-1:0]   rd_cnt_q;
	logic [DEPTH-1:0]    vld_q;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic                ins_s1;

	logic [SAMPLE_W-1:0] srt_q [WINDOW];
	logic [SAMPLE_W-1:0] ins_val;
	logic [WINDOW-1:0]   gt;

	logic                out_valid_q;
	logic [CHAN_W-1:0]   chan_out_q;
	logic [SAMPLE_W-1:0] filtered_q;

	logic [CH_IDX_W-1:0] ch_idx;
	logic [SLOT_W-1:0]   wslot;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	logic                do_write;
	logic [SAMPLE_W:0]   mid_sum;

	assign ch_idx   = CH_IDX_W'(chan_q);
	assign wslot    = slot_q[ch_idx];
	assign waddr    = ADDR_W'(int'(chan_q) * WINDOW + int'(wslot));
	assign raddr    = ADDR_W'(int'(chan_q) * WINDOW + int'(rd_cnt_q));
	assign do_write = cmd.write && chan_ok_q;

	assign sts.rd_last  = (int'(rd_cnt_q) == WINDOW - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	// Captured request fields.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			chan_q    <= channel;
			sample_q  <= sample;
			chan_ok_q <= (int'(channel) < CHANNELS);
		end
	end

	// Window memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[waddr] <= sample_q;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	// Control state: valid bits, slot pointers, read counter, pipeline flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_cnt_q  <= '0;
			ins_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			ins_s1 <= cmd.rd_issue;
			if (cmd.rd_issue) begin
				rd_vld_s1 <= vld_q[raddr];
			end
			if (do_write) begin
				vld_q[waddr] <= 1'b1;
				if (int'(wslot) == WINDOW - 1) begin
					slot_q[ch_idx] <= '0;
				end else begin
					slot_q[ch_idx] <= wslot + SLOT_W'(1);
				end
			end
			if (cmd.write) begin
				rd_cnt_q <= '0;
			end else if (cmd.rd_issue) begin
				rd_cnt_q <= rd_cnt_q + SLOT_W'(1);
			end
		end
	end

	// Entries never written read as the reset value of zero.
	assign ins_val = rd_vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			gt[i] = (srt_q[i] > ins_val);
		end
	end

	// Insertion sorter: ascending, preset to all ones so that after WINDOW
	// insertions it holds exactly the inserted values.
	always_ff @(posedge clk) begin
		if (cmd.clear_sort) begin
			for (int i = 0; i < WINDOW; i++) begin
				srt_q[i] <= '1;
			end
		end else if (ins_s1) begin
			for (int i = 0; i < WINDOW; i++) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					srt_q[i] <= srt_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i]) begin
					srt_q[i] <= ins_val;
				end
			end
		end
	end

	assign mid_sum = {1'b0, srt_q[MID_LO]} + {1'b0, srt_q[MID_HI]};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			chan_out_q <= chan_q;
			filtered_q <= chan_ok_q ? mid_sum[SAMPLE_W:1] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = chan_out_q;
	assign filtered    = filtered_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for per_channel_median_filter: random and directed samples,
// predicted per channel and compared result by result. Depends on pcmf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import pcmf_pkg::*;

	typedef struct {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] filtered;
	} filter_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CHAN_W-1:0]   channel = '0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CHAN_W-1:0]   channel_out;
	logic [SAMPLE_W-1:0] filtered;

	// Local copy of each channel's sample window and replacement pointer.
	logic [SAMPLE_W-1:0] chan_window [CHANNELS][WINDOW];
	int unsigned         chan_next_slot [CHANNELS];

	filter_result_t pending_results [$];
	int             error_count = 0;
	int             sender_idle_pct = 0;
	int             sink_stall_pct = 0;

	per_channel_median_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel_out (channel_out),
		.filtered    (filtered)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stores the sample in the channel's oldest slot, then ranks the window and
	// averages the two middle entries, rounding down.
	function automatic logic [SAMPLE_W-1:0] store_and_rank_middle(
		input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] ranked [WINDOW];
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W:0]   pair_sum;
		int                  k;
		if (ch >= CHANNELS)
			return '0;
		chan_window[ch][chan_next_slot[ch]] = s;
		chan_next_slot[ch] = (chan_next_slot[ch] == WINDOW - 1) ? 0 : chan_next_slot[ch] + 1;
		for (int i = 0; i < WINDOW; i++)
			ranked[i] = chan_window[ch][i];
		for (int i = 1; i < WINDOW; i++) begin
			v = ranked[i];
			k = i;
			while (k > 0 && ranked[k - 1] > v) begin
				ranked[k] = ranked[k - 1];
				k--;
			end
			ranked[k] = v;
		end
		pair_sum = {1'b0, ranked[MID_LO]} + {1'b0, ranked[MID_HI]};
		return pair_sum[SAMPLE_W:1];
	endfunction

	// Offers one request, with a random gap first, and records its expected result
	// at the edge where it is accepted. Valid stays high into the next request when
	// there is no gap.
	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		filter_result_t want;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		channel  <= ch;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		want.channel  = ch;
		want.filtered = store_and_rank_middle(ch, s);
		pending_results.push_back(want);
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver side: stall at the rate of the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// Result checker: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, channel_out %0d filtered %0d",
					$time, channel_out, filtered);
			end else begin
				want = pending_results.pop_front();
				if (channel_out !== want.channel) begin
					error_count++;
					$display("%0t: channel_out expected %0d, actual %0d",
						$time, want.channel, channel_out);
				end
				if (filtered !== want.filtered) begin
					error_count++;
					$display("%0t: filtered (channel %0d) expected %0d, actual %0d",
						$time, want.channel, want.filtered, filtered);
				end
			end
		end
	end

	// Right after reset the windows hold zeros, so a run of full-scale samples on
	// one channel reads 0, then the half-way average, then full scale; the eleventh
	// sample wraps the slot pointer.
	task automatic test_fresh_window();
		for (int i = 0; i < WINDOW + 1; i++)
			send_sample(2'd0, 12'hFFF);
	endtask

	task automatic test_field_extremes();
		send_sample(2'd3, 12'h000);
		send_sample(2'd3, 12'hFFF);
		send_sample(2'd3, 12'hFFF);
		send_sample(2'd3, 12'h001);
		send_sample(2'd3, 12'h800);
		// Odd pair sum: the average must round down.
		for (int i = 0; i < 5; i++)
			send_sample(2'd1, 12'hFFF);
		send_sample(2'd1, 12'hFFE);
		send_sample(2'd2, 12'h001);
	endtask

	// Sender holds off until every expected result is back, then resumes.
	task automatic test_pause_until_drained();
		for (int i = 0; i < 10; i++)
			send_sample(2'($urandom_range(0, CHANNELS - 1)), 12'($urandom_range(0, 4095)));
		wait_until_drained();
		for (int i = 0; i < 10; i++)
			send_sample(2'($urandom_range(0, CHANNELS - 1)), 12'($urandom_range(0, 4095)));
	endtask

	// Mixed traffic: bursts on one channel fill whole windows, clustered values
	// give ties in the ranking, and extremes appear often.
	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		logic [CHAN_W-1:0] ch;
		int                level;
		int                pick;
		int                value;
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		ch    = '0;
		level = $urandom_range(0, 4095);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 4)
				ch = 2'($urandom_range(0, CHANNELS - 1));
			if ($urandom_range(0, 31) == 0)
				level = $urandom_range(0, 4095);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				value = $urandom_range(0, 4095);
			else if (pick < 70)
				value = $urandom_range(0, 1) ? 4095 : 0;
			else begin
				value = level + $urandom_range(0, 6) - 3;
				value = (value < 0) ? 0 : (value > 4095) ? 4095 : value;
			end
			send_sample(ch, 12'(value));
			if ($urandom_range(0, 63) == 0)
				wait_until_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = 0; c < CHANNELS; c++) begin
			chan_next_slot[c] = 0;
			for (int w = 0; w < WINDOW; w++)
				chan_window[c][w] = '0;
		end

		test_fresh_window();
		test_field_extremes();
		test_random_traffic(295, 0, 0);
		test_random_traffic(295, 78, 0);
		test_pause_until_drained();
		test_random_traffic(295, 0, 78);
		test_random_traffic(295, 21, 21);

		wait_until_drained();
		// Let a stray extra result show up before the verdict.
		repeat (4 * (WINDOW + 4)) @(posedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
